/* hw/rtl/hbb_pkg.sv */
package hbb_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned WINDOW_DEF         = 64;
  localparam int unsigned MAX_WIDTH_BITS_DEF = 14;

  // Fixed field widths
  localparam int unsigned CH_W        = 8;
  localparam int unsigned ROW_WIDTH_W = 14;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(64);

  // Result buffer depth (also the number of results allowed in flight)
  localparam int unsigned OUT_DEPTH = 4;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic row_done;
    logic run_last;
  } res_flags_t;

  typedef struct packed {
    pixel_t     pix;
    res_flags_t flags;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_ALIGN,
    ST_FLUSH
  } hbb_state_e;

endpackage

/* hw/rtl/hbb_cell.sv */
module hbb_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  hbb_pkg::pixel_t pix_i,
  output hbb_pkg::pixel_t pix_o
);
  import hbb_pkg::*;

  pixel_t pix_q;

  // One pixel of the window; moves one cell toward the tail on each shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pix_q <= pix_i;
    end
  end

  assign pix_o = pix_q;

endmodule

/* hw/rtl/hbb_div.sv */
module hbb_div #(
  parameter int unsigned WINDOW = hbb_pkg::WINDOW_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_valid_i,
  input  logic [$clog2(255*WINDOW+1)-1:0]      req_sum_blue_i,
  input  logic [$clog2(255*WINDOW+1)-1:0]      req_sum_green_i,
  input  logic [$clog2(255*WINDOW+1)-1:0]      req_sum_red_i,
  input  logic [$clog2(WINDOW)-1:0]            req_div_m1_i,
  input  hbb_pkg::res_flags_t                  req_flags_i,
  output logic                                 res_valid_o,
  output hbb_pkg::out_beat_t                   res_beat_o
);
  import hbb_pkg::*;

  localparam int unsigned SUM_W  = $clog2(255*WINDOW+1);
  localparam int unsigned DM1_W  = $clog2(WINDOW);
  localparam int unsigned K      = SUM_W + $clog2(WINDOW+1);
  localparam int unsigned RCP_W  = K + 1;
  localparam int unsigned PROD_W = SUM_W + RCP_W;
  localparam int unsigned TAB_N  = 2**DM1_W;

  // Reciprocal table: ceil(2^K / d), indexed by d-1. Exact floor for sums below 2^SUM_W.
  logic [RCP_W-1:0] rcp_tab [TAB_N];

  for (genvar gi = 0; gi < TAB_N; gi++) begin : g_rcp
    if (gi < WINDOW) begin : g_used
      localparam longint unsigned RCP = ((64'd1 << K) + 64'(gi)) / 64'(gi + 1);
      assign rcp_tab[gi] = RCP_W'(RCP);
    end else begin : g_unused
      assign rcp_tab[gi] = '0;
    end
  end

  logic              s1_valid_q;
  logic [SUM_W-1:0]  s1_sum_b_q, s1_sum_g_q, s1_sum_r_q;
  logic [RCP_W-1:0]  s1_rcp_q;
  res_flags_t        s1_flags_q;
  logic              s2_valid_q;
  logic [PROD_W-1:0] s2_prod_b_q, s2_prod_g_q, s2_prod_r_q;
  res_flags_t        s2_flags_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Stage 1: capture sums and look up the reciprocal
  always_ff @(posedge clk_i) begin
    s1_sum_b_q <= req_sum_blue_i;
    s1_sum_g_q <= req_sum_green_i;
    s1_sum_r_q <= req_sum_red_i;
    s1_rcp_q   <= rcp_tab[req_div_m1_i];
    s1_flags_q <= req_flags_i;
  end

  // Stage 2: one multiplier per channel
  always_ff @(posedge clk_i) begin
    s2_prod_b_q <= PROD_W'(s1_sum_b_q) * PROD_W'(s1_rcp_q);
    s2_prod_g_q <= PROD_W'(s1_sum_g_q) * PROD_W'(s1_rcp_q);
    s2_prod_r_q <= PROD_W'(s1_sum_r_q) * PROD_W'(s1_rcp_q);
    s2_flags_q  <= s1_flags_q;
  end

  // Quotient is the product scaled down by 2^K
  always_comb begin
    res_beat_o.pix.blue  = s2_prod_b_q[K +: CH_W];
    res_beat_o.pix.green = s2_prod_g_q[K +: CH_W];
    res_beat_o.pix.red   = s2_prod_r_q[K +: CH_W];
    res_beat_o.flags     = s2_flags_q;
  end

  assign res_valid_o = s2_valid_q;

endmodule

/* hw/rtl/hbb_out_fifo.sv */
module hbb_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hbb_pkg::out_beat_t push_beat_i,
  input  logic               pop_ready_i,
  output logic               pop_valid_o,
  output hbb_pkg::out_beat_t pop_beat_o
);
  import hbb_pkg::*;

  localparam int unsigned PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

  out_beat_t        mem_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;

  // Space is guaranteed upstream by the credit counter
  assign pop = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(push_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_beat_i;
    end
  end

  assign pop_valid_o = (count_q != '0);
  assign pop_beat_o  = mem_q[rd_ptr_q];

endmodule

/* hw/rtl/horizontal_box_blur_unit.sv */
// Horizontal box blur over a stream of 24-bit BGR pixels in row order.
// Input channel: in_valid_i/in_ready_o with in_blue_i, in_green_i, in_red_i.
// Output channel: out_valid_o/out_ready_i with the averaged channels plus
// out_row_done_o (final column of a row) and out_run_last_o (last result of
// the input beat that caused it). The user must write row_width through
// cfg_we_i and cfg_data_i only while the block is idle; the block does not
// enforce this. Each output column j is the mean of pixels j..j+WINDOW-1,
// cut at row end. Mid-row, one pixel is taken per cycle; the pixel completing
// a window sends its result through both divide stages and the result buffer.
// The last pixel of a row starts a drain through the tail of the cell chain:
// first WINDOW-fill alignment shifts, then one result per cycle. Division
// uses a reciprocal table and one multiplier per channel, two stages. A
// 4-entry result buffer absorbs receiver stalls; when the results in it and
// in the divide pipeline reach its depth, in_ready_o drops and draining
// pauses. Reset clears sums, counters and all valid state and sets row_width
// to 64; the pixel chain is left as is and needs no clearing.
module horizontal_box_blur_unit #(
  parameter int unsigned WINDOW         = hbb_pkg::WINDOW_DEF,
  parameter int unsigned MAX_WIDTH_BITS = hbb_pkg::MAX_WIDTH_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hbb_pkg::ROW_WIDTH_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [hbb_pkg::CH_W-1:0]           in_blue_i,
  input  logic [hbb_pkg::CH_W-1:0]           in_green_i,
  input  logic [hbb_pkg::CH_W-1:0]           in_red_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [hbb_pkg::CH_W-1:0]           out_blue_o,
  output logic [hbb_pkg::CH_W-1:0]           out_green_o,
  output logic [hbb_pkg::CH_W-1:0]           out_red_o,
  output logic                               out_row_done_o,
  output logic                               out_run_last_o
);
  import hbb_pkg::*;

  localparam int unsigned SUM_W  = $clog2(255*WINDOW+1);
  localparam int unsigned FILL_W = $clog2(WINDOW+1);
  localparam int unsigned DM1_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = MAX_WIDTH_BITS;
  localparam int unsigned CMP_W  = (CNT_W + 1 > ROW_WIDTH_W) ? CNT_W + 1 : ROW_WIDTH_W;
  localparam int unsigned OC_W   = $clog2(OUT_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

  hbb_state_e          state_q, state_d;
  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic [SUM_W-1:0]    sum_b_q, sum_b_d, sum_g_q, sum_g_d, sum_r_q, sum_r_d;
  logic [SUM_W-1:0]    sum_b_new, sum_g_new, sum_r_new;
  logic [FILL_W-1:0]   fill_q, fill_d, fill_inc;
  logic [FILL_W-1:0]   lead_q, lead_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W:0]      count_inc;
  logic [OC_W-1:0]     outstanding_q, outstanding_d;
  logic                fill_full, row_end, credit_ok;
  logic                accept, shift, emit, pop;
  pixel_t              in_pix, add_pix, drop_pix;
  pixel_t              chain_q [WINDOW];
  logic [DM1_W-1:0]    req_div_m1;
  logic [SUM_W-1:0]    req_sum_b, req_sum_g, req_sum_r;
  res_flags_t          req_flags;
  logic                res_valid;
  out_beat_t           res_beat, pop_beat;

  assign in_pix = '{red: in_red_i, green: in_green_i, blue: in_blue_i};

  // Cell chain: newest pixel at the head, oldest leaves at the tail
  for (genvar i = 0; i < WINDOW; i++) begin : g_chain
    if (i == 0) begin : g_head
      hbb_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .pix_i   (in_pix),
        .pix_o   (chain_q[i])
      );
    end else begin : g_body
      hbb_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .pix_i   (chain_q[i-1]),
        .pix_o   (chain_q[i])
      );
    end
  end

  // Running sums, fill and row position
  always_comb begin
    fill_full = (fill_q == FILL_FULL);
    drop_pix  = '0;
    if ((state_q == ST_RUN && fill_full) || state_q == ST_FLUSH) begin
      drop_pix = chain_q[WINDOW-1];
    end
    add_pix   = (state_q == ST_RUN) ? in_pix : '0;
    sum_b_new = sum_b_q - SUM_W'(drop_pix.blue) + SUM_W'(add_pix.blue);
    sum_g_new = sum_g_q - SUM_W'(drop_pix.green) + SUM_W'(add_pix.green);
    sum_r_new = sum_r_q - SUM_W'(drop_pix.red) + SUM_W'(add_pix.red);
    fill_inc  = fill_full ? fill_q : fill_q + 1'b1;
    count_inc = {1'b0, count_q} + 1'b1;
    row_end   = !(CMP_W'(count_inc) < CMP_W'(row_width_q));
  end

  assign credit_ok = (outstanding_q < OC_W'(OUT_DEPTH));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (accept && row_end) begin
          state_d = (fill_inc == FILL_FULL) ? ST_FLUSH : ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (lead_q == FILL_W'(1)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (shift && fill_q == FILL_W'(1)) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // Control outputs and result requests
  always_comb begin
    in_ready_o = 1'b0;
    accept     = 1'b0;
    shift      = 1'b0;
    emit       = 1'b0;
    req_div_m1 = DM1_W'(WINDOW - 1);
    req_flags  = '{row_done: 1'b0, run_last: 1'b1};
    unique case (state_q)
      ST_RUN: begin
        in_ready_o = credit_ok;
        accept     = in_valid_i && credit_ok;
        shift      = accept;
        emit       = accept && !row_end && (fill_inc == FILL_FULL);
      end
      ST_ALIGN: begin
        shift = 1'b1;
      end
      ST_FLUSH: begin
        shift      = credit_ok;
        emit       = credit_ok;
        req_div_m1 = DM1_W'(fill_q - 1'b1);
        req_flags  = '{row_done: fill_q == FILL_W'(1), run_last: fill_q == FILL_W'(1)};
      end
      default: ;
    endcase
    req_sum_b = (state_q == ST_RUN) ? sum_b_new : sum_b_q;
    req_sum_g = (state_q == ST_RUN) ? sum_g_new : sum_g_q;
    req_sum_r = (state_q == ST_RUN) ? sum_r_new : sum_r_q;
  end

  // Register next values
  always_comb begin
    sum_b_d = sum_b_q;
    sum_g_d = sum_g_q;
    sum_r_d = sum_r_q;
    fill_d  = fill_q;
    count_d = count_q;
    lead_d  = lead_q;
    if (accept) begin
      sum_b_d = sum_b_new;
      sum_g_d = sum_g_new;
      sum_r_d = sum_r_new;
      fill_d  = fill_inc;
      if (row_end) begin
        count_d = '0;
        lead_d  = FILL_FULL - fill_inc;
      end else begin
        count_d = count_inc[CNT_W-1:0];
      end
    end
    if (state_q == ST_ALIGN) begin
      lead_d = lead_q - 1'b1;
    end
    if (state_q == ST_FLUSH && shift) begin
      sum_b_d = sum_b_new;
      sum_g_d = sum_g_new;
      sum_r_d = sum_r_new;
      fill_d  = fill_q - 1'b1;
    end
  end

  // Results in flight or buffered
  assign pop           = out_valid_o && out_ready_i;
  assign outstanding_d = outstanding_q + OC_W'(emit) - OC_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_RUN;
      row_width_q   <= ROW_WIDTH_RST;
      sum_b_q       <= '0;
      sum_g_q       <= '0;
      sum_r_q       <= '0;
      fill_q        <= '0;
      count_q       <= '0;
      lead_q        <= '0;
      outstanding_q <= '0;
    end else begin
      state_q       <= state_d;
      if (cfg_we_i) begin
        row_width_q <= cfg_data_i;
      end
      sum_b_q       <= sum_b_d;
      sum_g_q       <= sum_g_d;
      sum_r_q       <= sum_r_d;
      fill_q        <= fill_d;
      count_q       <= count_d;
      lead_q        <= lead_d;
      outstanding_q <= outstanding_d;
    end
  end

  hbb_div #(
    .WINDOW (WINDOW)
  ) u_div (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (emit),
    .req_sum_blue_i  (req_sum_b),
    .req_sum_green_i (req_sum_g),
    .req_sum_red_i   (req_sum_r),
    .req_div_m1_i    (req_div_m1),
    .req_flags_i     (req_flags),
    .res_valid_o     (res_valid),
    .res_beat_o      (res_beat)
  );

  hbb_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_beat_i (res_beat),
    .pop_ready_i (out_ready_i),
    .pop_valid_o (out_valid_o),
    .pop_beat_o  (pop_beat)
  );

  assign out_blue_o     = pop_beat.pix.blue;
  assign out_green_o    = pop_beat.pix.green;
  assign out_red_o      = pop_beat.pix.red;
  assign out_row_done_o = pop_beat.flags.row_done;
  assign out_run_last_o = pop_beat.flags.run_last;

  // Credit count never passes the buffer depth
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= OC_W'(OUT_DEPTH))
    else $error("result credit count overflow");

  // Window fill stays within the chain length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("window fill beyond WINDOW");

  // While aligning, the oldest pixel is lead_q shifts from the tail
  a_align_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ALIGN |-> ((FILL_W+1)'(fill_q) + (FILL_W+1)'(lead_q)
                             <= (FILL_W+1)'(WINDOW)) && lead_q != '0)
    else $error("alignment count out of step with fill");

  // A finished flush leaves the window empty and the sums at zero
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && shift && fill_q == FILL_W'(1)) |=>
      (fill_q == '0 && sum_b_q == '0 && sum_g_q == '0 && sum_r_q == '0
       && count_q == '0 && state_q == ST_RUN))
    else $error("row flush left state behind");

  // Divider output must always find room in the result buffer
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> credit_ok)
    else $error("result issued without credit");

endmodule
